// ===== design/gtbr_pkg.sv =====
// shared types and constants for the two-border reach flood block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gtbr_pkg;
	// grid limits and height width
	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 32;
	localparam int HEIGHT_BITS = 16;
	localparam int CELLS       = MAX_ROWS * MAX_COLS;
	localparam int IDX_W       = $clog2(CELLS);
	localparam int CNT_W       = $clog2(CELLS + 1);
	localparam int ROW_W       = $clog2(MAX_ROWS + 1);
	localparam int COL_W       = $clog2(MAX_COLS + 1);

	localparam logic [0:0] REG_GRID_ROWS = 1'b0;
	localparam logic [0:0] REG_GRID_COLS = 1'b1;

	// neighbour directions, visited in this order
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SEED,
		ST_SEEDW,
		ST_POP,
		ST_POPW,
		ST_NBR,
		ST_NBRW,
		ST_NEXT_OCEAN,
		ST_EMIT,
		ST_EMITW
	} state_t;
endpackage
`default_nettype wire

// ===== design/grid_two_border_reach_flood_core.sv =====
// top level of the two-border reach flood block: load, fill and row output
// depends on gtbr_pkg
`timescale 1ns / 1ps
`default_nettype none
// usage
//  - configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 sets
//    grid_rows, index 1 grid_cols; any write restarts loading at cell zero;
//    cfg_ready is low while busy or while start is high, so an item wins a tie
//  - cells: cell_height is taken when start is high and busy is low, one cell per
//    cycle in row-major order; the item that completes the grid raises busy
//  - per ocean: a scan marks the border seeds (the first scan also clears both
//    reach flags of every cell), then each queued cell is popped and read, and
//    its four directions are checked in turn, with a read and a write for each
//    in-bounds neighbour; an empty pop ends the fill and a switch state follows
//  - output: each cell is read in turn, in row-major order; result_valid is high
//    one cycle with row_index, reach_mask, last_row at the end of each row
//  - busy drops in the cycle that carries the last row
//  - the receiver cannot stall; nothing waits on it
//  - reset: sizes go to 32, load count to zero, state to loading; no clearing
//    pass is needed since the first seed scan of every grid clears the flags
module grid_two_border_reach_flood_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] cell_height,
	output logic             result_valid,
	output logic [4:0]       row_index,
	output logic [31:0]      reach_mask,
	output logic             last_row
);
	localparam int CELLS = gtbr_pkg::CELLS;
	localparam int IW    = gtbr_pkg::IDX_W;
	localparam int NW    = gtbr_pkg::CNT_W;
	localparam int RW    = gtbr_pkg::ROW_W;
	localparam int CW    = gtbr_pkg::COL_W;
	localparam int HB    = gtbr_pkg::HEIGHT_BITS;

	gtbr_pkg::state_t state_q, state_d;

	logic [5:0]    rows_cfg_q, cols_cfg_q;
	logic [RW-1:0] rows;
	logic [CW-1:0] cols;
	logic [NW-1:0] total;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] load_q;

	// memories: heights, reach flags {second, first}, queue of {row, col}
	logic [HB-1:0]    hmem [CELLS];
	logic [1:0]       rmem [CELLS];
	logic [RW+CW-1:0] qmem [CELLS];
	logic [HB-1:0]    hrd_q;
	logic [1:0]       rrd_q;
	logic [RW+CW-1:0] qrd_q;

	logic          ocean_q;      // 0 first, 1 second
	logic [IW-1:0] idx_q;
	logic [NW-1:0] head_q, tail_q;
	logic [RW-1:0] y_q, cy_q;
	logic [CW-1:0] x_q, cx_q;
	logic [1:0]    dir_q;
	logic [HB-1:0] hcur_q;
	logic [31:0]   mask_q;

	// size clamp: zero counts as one, large values saturate
	always_comb begin
		if (rows_cfg_q == 6'd0) rows = RW'(1);
		else if (32'(rows_cfg_q) > gtbr_pkg::MAX_ROWS) rows = RW'(gtbr_pkg::MAX_ROWS);
		else rows = RW'(rows_cfg_q);
		if (cols_cfg_q == 6'd0) cols = CW'(1);
		else if (32'(cols_cfg_q) > gtbr_pkg::MAX_COLS) cols = CW'(gtbr_pkg::MAX_COLS);
		else cols = CW'(cols_cfg_q);
	end

	assign total    = NW'(rows) * NW'(cols);
	assign last_idx = IW'(total - NW'(1));

	// neighbour coordinates
	logic          nb_ok;
	logic [RW-1:0] ny;
	logic [CW-1:0] nx;
	always_comb begin
		ny = cy_q;
		nx = cx_q;
		nb_ok = 1'b0;
		case (dir_q)
			gtbr_pkg::DIR_UP: begin ny = cy_q - RW'(1); nb_ok = (cy_q != '0); end
			gtbr_pkg::DIR_RIGHT: begin nx = cx_q + CW'(1); nb_ok = (cx_q + CW'(1) < cols); end
			gtbr_pkg::DIR_DOWN: begin ny = cy_q + RW'(1); nb_ok = (cy_q + RW'(1) < rows); end
			default: begin nx = cx_q - CW'(1); nb_ok = (cx_q != '0); end
		endcase
	end

	// linear addresses of the neighbour and of the popped cell
	logic [IW-1:0] nidx, cur_idx;
	assign nidx    = IW'(ny) * IW'(cols) + IW'(nx);
	assign cur_idx = IW'(qrd_q[RW+CW-1:CW]) * IW'(cols) + IW'(qrd_q[CW-1:0]);

	logic seed;
	assign seed = ocean_q ? (y_q == rows - RW'(1) || x_q == cols - CW'(1))
	                      : (y_q == '0 || x_q == '0);

	// neighbour joins the fill when not yet reached and not lower
	logic nb_seen, nb_take;
	assign nb_seen = ocean_q ? rrd_q[1] : rrd_q[0];
	assign nb_take = !nb_seen && (hrd_q >= hcur_q);

	logic accept;
	assign busy      = (state_q != gtbr_pkg::ST_LOAD);
	assign cfg_ready = !busy && !start;
	assign accept    = start && !busy;

	// memory address/write control
	logic             h_we, r_we, q_we;
	logic [IW-1:0]    h_addr, r_addr, q_addr;
	logic [1:0]       r_wd;
	logic [RW+CW-1:0] q_wd;
	always_comb begin
		h_we = 1'b0; r_we = 1'b0; q_we = 1'b0;
		r_wd = rrd_q; q_wd = {y_q, x_q};
		h_addr = load_q; r_addr = idx_q; q_addr = head_q[IW-1:0];
		case (state_q)
			gtbr_pkg::ST_LOAD: h_we = accept;
			gtbr_pkg::ST_SEED: r_addr = idx_q;
			gtbr_pkg::ST_SEEDW: begin
				// first scan rewrites every cell, second keeps the first flag
				r_addr = idx_q;
				r_we = !ocean_q || seed;
				r_wd = ocean_q ? {1'b1, rrd_q[0]} : {1'b0, seed};
				q_we = seed; q_addr = tail_q[IW-1:0];
			end
			gtbr_pkg::ST_POP: q_addr = head_q[IW-1:0];
			gtbr_pkg::ST_POPW: h_addr = cur_idx;
			gtbr_pkg::ST_NBR: begin h_addr = nidx; r_addr = nidx; end
			gtbr_pkg::ST_NBRW: begin
				r_addr = nidx; q_addr = tail_q[IW-1:0];
				r_we = nb_take;
				r_wd = ocean_q ? {1'b1, rrd_q[0]} : {rrd_q[1], 1'b1};
				q_we = nb_take; q_wd = {ny, nx};
			end
			gtbr_pkg::ST_EMIT: r_addr = idx_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) hmem[h_addr] <= cell_height[HB-1:0];
		hrd_q <= hmem[h_addr];
		if (r_we) rmem[r_addr] <= r_wd;
		rrd_q <= rmem[r_addr];
		if (q_we) qmem[q_addr] <= q_wd;
		qrd_q <= qmem[q_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gtbr_pkg::ST_LOAD:
				if (accept && load_q == last_idx) state_d = gtbr_pkg::ST_SEED;
			gtbr_pkg::ST_SEED: state_d = gtbr_pkg::ST_SEEDW;
			gtbr_pkg::ST_SEEDW:
				state_d = (idx_q == last_idx) ? gtbr_pkg::ST_POP : gtbr_pkg::ST_SEED;
			gtbr_pkg::ST_POP:
				state_d = (head_q == tail_q) ? gtbr_pkg::ST_NEXT_OCEAN : gtbr_pkg::ST_POPW;
			gtbr_pkg::ST_POPW: state_d = gtbr_pkg::ST_NBR;
			gtbr_pkg::ST_NBR:
				if (nb_ok) state_d = gtbr_pkg::ST_NBRW;
				else if (dir_q == gtbr_pkg::DIR_LEFT) state_d = gtbr_pkg::ST_POP;
			gtbr_pkg::ST_NBRW:
				state_d = (dir_q == gtbr_pkg::DIR_LEFT) ? gtbr_pkg::ST_POP : gtbr_pkg::ST_NBR;
			gtbr_pkg::ST_NEXT_OCEAN:
				state_d = ocean_q ? gtbr_pkg::ST_EMIT : gtbr_pkg::ST_SEED;
			gtbr_pkg::ST_EMIT: state_d = gtbr_pkg::ST_EMITW;
			gtbr_pkg::ST_EMITW:
				if (idx_q == last_idx) state_d = gtbr_pkg::ST_LOAD;
				else state_d = gtbr_pkg::ST_EMIT;
			default: state_d = gtbr_pkg::ST_LOAD;
		endcase
	end

	// output strobe: the emit read finishes a row at its last column
	logic emit_done;
	assign emit_done = (state_q == gtbr_pkg::ST_EMITW) && (x_q == cols - CW'(1));
	logic bit_now;
	assign bit_now = rrd_q[0] && rrd_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtbr_pkg::ST_LOAD;
			rows_cfg_q <= 6'd32;
			cols_cfg_q <= 6'd32;
			load_q <= '0;
			result_valid <= 1'b0;
			ocean_q <= 1'b0;
		end else begin
			state_q <= state_d;
			result_valid <= emit_done;
			if (cfg_valid && cfg_ready) begin
				load_q <= '0;
				case (cfg_index)
					gtbr_pkg::REG_GRID_ROWS: rows_cfg_q <= cfg_data;
					gtbr_pkg::REG_GRID_COLS: cols_cfg_q <= cfg_data;
					default: ;
				endcase
			end else if (accept) begin
				load_q <= (load_q == last_idx) ? '0 : load_q + IW'(1);
			end
			if (state_q == gtbr_pkg::ST_NEXT_OCEAN) ocean_q <= !ocean_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			gtbr_pkg::ST_LOAD: begin
				idx_q <= '0; y_q <= '0; x_q <= '0; head_q <= '0; tail_q <= '0;
			end
			gtbr_pkg::ST_SEEDW: begin
				idx_q <= idx_q + IW'(1);
				if (seed) tail_q <= tail_q + NW'(1);
				if (x_q == cols - CW'(1)) begin x_q <= '0; y_q <= y_q + RW'(1); end
				else x_q <= x_q + CW'(1);
			end
			gtbr_pkg::ST_POP: begin
				head_q <= head_q + NW'(1);
				dir_q <= gtbr_pkg::DIR_UP;
			end
			gtbr_pkg::ST_POPW: begin
				cy_q <= qrd_q[RW+CW-1:CW];
				cx_q <= qrd_q[CW-1:0];
			end
			gtbr_pkg::ST_NBR: begin
				// first neighbour cycle still sees the popped cell's height
				if (dir_q == gtbr_pkg::DIR_UP) hcur_q <= hrd_q;
				if (!nb_ok) dir_q <= dir_q + 2'd1;
			end
			gtbr_pkg::ST_NBRW: begin
				if (nb_take) tail_q <= tail_q + NW'(1);
				dir_q <= dir_q + 2'd1;
			end
			gtbr_pkg::ST_NEXT_OCEAN: begin
				idx_q <= '0; y_q <= '0; x_q <= '0; mask_q <= '0;
				head_q <= '0; tail_q <= '0;
			end
			gtbr_pkg::ST_EMITW: begin
				idx_q <= idx_q + IW'(1);
				if (x_q == cols - CW'(1)) begin
					row_index <= 5'(y_q);
					reach_mask <= mask_q | (bit_now ? (32'd1 << x_q) : 32'd0);
					last_row <= (y_q == rows - RW'(1));
					mask_q <= '0; x_q <= '0; y_q <= y_q + RW'(1);
				end else begin
					mask_q <= mask_q | (bit_now ? (32'd1 << x_q) : 32'd0);
					x_q <= x_q + CW'(1);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
